>>> rtl/text_console_scroll_writer_unit_defines.svh
// ----------------------------------------------------------------------------
// text_console_scroll_writer_unit_defines: assertion macros
// Shared concurrent check forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_SCROLL_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_SCROLL_WRITER_UNIT_DEFINES_SVH

// same-cycle implication
`define TCSW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCSW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tcsw_pkg.sv
// ----------------------------------------------------------------------------
// tcsw_pkg: shared types and constants for the text console
// Word formats, command codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tcsw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam int CFG_IW = 2;

	// command codes
	localparam logic [1:0] CMD_STREAM = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_FG = 2'd0;
	localparam logic [CFG_IW-1:0] REG_BG = 2'd1;

	localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
	localparam logic [7:0]  SPACE_CODE   = 8'h20;
	localparam logic [15:0] BLANK_CELL   = 16'h0F20;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] char_code;
		logic [4:0] row_index;
		logic [6:0] column_index;
		logic [3:0] cell_foreground;
		logic [3:0] cell_background;
	} item_t;

	typedef struct packed {
		logic [15:0] cell_word;
		logic [6:0]  cursor_column;
		logic        position_error;
	} result_t;

	// write source select
	typedef enum logic [1:0] {
		WS_CURSOR,
		WS_POS,
		WS_BLANK,
		WS_FILL
	} wsel_t;

	// sweep pointer start
	typedef enum logic [1:0] {
		PI_ZERO,
		PI_ROW1,
		PI_BOTTOM
	} ptr_init_t;

	typedef enum logic [1:0] {
		CO_HOLD,
		CO_ZERO,
		CO_INC
	} cur_op_t;

	typedef struct packed {
		logic      item_live;
		logic      item_load;
		logic      mem_we;
		wsel_t     wsel;
		logic      rd_ptr;
		logic      copy_rd;
		logic      ptr_set;
		ptr_init_t ptr_start;
		logic      ptr_inc;
		cur_op_t   cursor_op;
		logic      out_load;
		logic      out_from_mem;
		logic      out_err;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       newline;
		logic       line_full;
		logic       in_range;
		logic       ptr_last;
		logic       copy_pending;
		logic       out_free;
	} ctl_stat_t;

	function automatic logic [15:0] make_cell(logic [3:0] bg, logic [3:0] fg,
		logic [7:0] ch);
		return {bg, fg, ch};
	endfunction

endpackage

>>> rtl/text_console_scroll_writer_unit.sv
// Stream character, positioned write, out-of-range read: result in the cycle after accept;
// in-range read: registered read of the screen store, then the result register, input held off.
// Scroll: copy pass, bottom-row fill, then a put for a character that arrived on a full line;
// clear: one blanking pass. Both walk the store one cell a cycle, input held off.
// Throughput: one word a cycle for stream without scroll and write, while result_ready is high.
// Reset: clearing pass over all ROWS*COLUMNS cells (2000 by default), no item taken, config taken.
// ----------------------------------------------------------------------------
// text_console_scroll_writer_unit: text-mode console with scrolling bottom line
// Controller and datapath joined by command and status structs.
// ----------------------------------------------------------------------------
module text_console_scroll_writer_unit
	import tcsw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [3:0]        cfg_data
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	tcsw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	tcsw_dpath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule

>>> rtl/tcsw_dpath.sv
// ----------------------------------------------------------------------------
// tcsw_dpath: screen store, sweep pointer, cursor and result register
// Executes the controller's commands and reports item and sweep status.
// ----------------------------------------------------------------------------
module tcsw_dpath
	import tcsw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  item_t             item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [3:0]        cfg_data,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  ctl_cmd_t          cmd,
	output ctl_stat_t         stat
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CURW  = $clog2(COLUMNS + 1);

	logic [15:0]   mem [CELLS];
	logic [15:0]   rd_data_q;
	logic [AW-1:0] ptr_q;
	logic [CURW-1:0] cursor_q, cursor_nxt;
	logic [3:0]    fg_q, bg_q;
	item_t         item_q, cur;
	result_t       result_q;
	logic          result_valid_q;
	logic          copy_s1;
	logic [AW-1:0] waddr_s1;
	logic [AW-1:0] pos_addr, bottom_addr, wr_addr, rd_addr;
	logic [15:0]   wr_data;
	logic [7:0]    cursor_wide;

	assign cfg_ready = 1'b1;

	// current item: live input while idle, latched copy afterwards
	assign cur = cmd.item_live ? item : item_q;

	assign pos_addr    = AW'(AW'(cur.row_index) * AW'(COLUMNS)) + AW'(cur.column_index);
	assign bottom_addr = AW'((ROWS - 1) * COLUMNS) + AW'(cursor_q);

	assign stat.command      = cur.command;
	assign stat.newline      = (cur.char_code == NEWLINE_CODE);
	assign stat.line_full    = (cursor_q >= CURW'(COLUMNS));
	assign stat.in_range     = (32'(cur.row_index) < ROWS) && (32'(cur.column_index) < COLUMNS);
	assign stat.ptr_last     = (ptr_q == AW'(CELLS - 1));
	assign stat.copy_pending = copy_s1;
	assign stat.out_free     = !result_valid_q || result_ready;

	// write source
	always_comb begin
		unique case (cmd.wsel)
			WS_CURSOR: begin
				wr_addr = bottom_addr;
				wr_data = make_cell(bg_q, fg_q, cur.char_code);
			end
			WS_POS: begin
				wr_addr = pos_addr;
				wr_data = make_cell(cur.cell_background, cur.cell_foreground, cur.char_code);
			end
			WS_BLANK: begin
				wr_addr = ptr_q;
				wr_data = BLANK_CELL;
			end
			WS_FILL: begin
				wr_addr = ptr_q;
				wr_data = make_cell(bg_q, bg_q, SPACE_CODE);
			end
			default: begin
				wr_addr = ptr_q;
				wr_data = BLANK_CELL;
			end
		endcase
	end

	assign rd_addr = cmd.rd_ptr ? ptr_q : pos_addr;

	// screen store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (copy_s1) begin
			mem[waddr_s1] <= rd_data_q;
		end else if (cmd.mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// copy write lands in the cycle after its read, one row up
	always_ff @(posedge clk) begin
		waddr_s1 <= ptr_q - AW'(COLUMNS);
	end

	// cursor update
	always_comb begin
		unique case (cmd.cursor_op)
			CO_HOLD: cursor_nxt = cursor_q;
			CO_ZERO: cursor_nxt = '0;
			CO_INC:  cursor_nxt = cursor_q + CURW'(1);
			default: cursor_nxt = cursor_q;
		endcase
	end

	assign cursor_wide = 8'(cursor_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q          <= '0;
			cursor_q       <= '0;
			fg_q           <= 4'hF;
			bg_q           <= 4'h0;
			copy_s1        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			copy_s1  <= cmd.copy_rd;
			cursor_q <= cursor_nxt;
			// sweep pointer
			if (cmd.ptr_set) begin
				unique case (cmd.ptr_start)
					PI_ZERO:   ptr_q <= '0;
					PI_ROW1:   ptr_q <= AW'(COLUMNS);
					PI_BOTTOM: ptr_q <= AW'(CELLS - COLUMNS);
					default:   ptr_q <= '0;
				endcase
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + AW'(1);
			end
			// color registers
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FG:  fg_q <= cfg_data;
					REG_BG:  bg_q <= cfg_data;
					default: ;
				endcase
			end
			// result word handshake
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			item_q <= item;
		end
		if (cmd.out_load) begin
			result_q.cell_word      <= cmd.out_from_mem ? rd_data_q : 16'h0000;
			result_q.cursor_column  <= cursor_wide[6:0];
			result_q.position_error <= cmd.out_err;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> rtl/tcsw_ctrl.sv
// ----------------------------------------------------------------------------
// tcsw_ctrl: command sequencer for the text console
// Accepts items, runs scroll, clear and read sequences over the datapath.
// ----------------------------------------------------------------------------
`include "text_console_scroll_writer_unit_defines.svh"

module tcsw_ctrl
	import tcsw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	output ctl_cmd_t  cmd,
	input  ctl_stat_t stat
);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_COPY  = 3'd2;
	localparam logic [2:0] S_FILL  = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;
	localparam logic [2:0] S_CLEAR = 3'd5;
	localparam logic [2:0] S_READ  = 3'd6;

	logic [2:0] state_q, state_nxt;
	logic       accept;

	assign item_ready = (state_q == S_IDLE) && stat.out_free;
	assign accept     = item_valid && item_ready;

	// next state and datapath commands
	always_comb begin
		state_nxt        = state_q;
		cmd.item_live    = 1'b0;
		cmd.item_load    = 1'b0;
		cmd.mem_we       = 1'b0;
		cmd.wsel         = WS_CURSOR;
		cmd.rd_ptr       = 1'b0;
		cmd.copy_rd      = 1'b0;
		cmd.ptr_set      = 1'b0;
		cmd.ptr_start    = PI_ZERO;
		cmd.ptr_inc      = 1'b0;
		cmd.cursor_op    = CO_HOLD;
		cmd.out_load     = 1'b0;
		cmd.out_from_mem = 1'b0;
		cmd.out_err      = 1'b0;
		unique case (state_q)
			S_INIT: begin
				// clearing pass after reset
				cmd.mem_we  = 1'b1;
				cmd.wsel    = WS_BLANK;
				cmd.rd_ptr  = 1'b1;
				cmd.ptr_inc = 1'b1;
				if (stat.ptr_last) begin
					cmd.cursor_op = CO_ZERO;
					state_nxt     = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.item_live = 1'b1;
				if (accept) begin
					cmd.item_load = 1'b1;
					unique case (stat.command)
						CMD_STREAM: begin
							if (stat.newline || stat.line_full) begin
								cmd.ptr_set   = 1'b1;
								cmd.ptr_start = PI_ROW1;
								state_nxt     = S_COPY;
							end else begin
								cmd.mem_we    = 1'b1;
								cmd.wsel      = WS_CURSOR;
								cmd.cursor_op = CO_INC;
								cmd.out_load  = 1'b1;
							end
						end
						CMD_WRITE: begin
							cmd.mem_we   = stat.in_range;
							cmd.wsel     = WS_POS;
							cmd.out_load = 1'b1;
							cmd.out_err  = !stat.in_range;
						end
						CMD_CLEAR: begin
							cmd.ptr_set   = 1'b1;
							cmd.ptr_start = PI_ZERO;
							state_nxt     = S_CLEAR;
						end
						CMD_READ: begin
							if (stat.in_range) begin
								state_nxt = S_READ;
							end else begin
								cmd.out_load = 1'b1;
								cmd.out_err  = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_COPY: begin
				// move each cell up one row
				cmd.rd_ptr  = 1'b1;
				cmd.copy_rd = 1'b1;
				if (stat.ptr_last) begin
					cmd.ptr_set   = 1'b1;
					cmd.ptr_start = PI_BOTTOM;
					state_nxt     = S_FILL;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			S_FILL: begin
				// fill bottom row once the last copy write has landed
				cmd.rd_ptr = 1'b1;
				if (!stat.copy_pending) begin
					cmd.mem_we  = 1'b1;
					cmd.wsel    = WS_FILL;
					cmd.ptr_inc = 1'b1;
					if (stat.ptr_last) begin
						cmd.cursor_op = CO_ZERO;
						if (stat.newline) begin
							cmd.out_load = 1'b1;
							state_nxt    = S_IDLE;
						end else begin
							state_nxt = S_PUT;
						end
					end
				end
			end
			S_PUT: begin
				// character that arrived on a full line, now at column 0
				cmd.mem_we    = 1'b1;
				cmd.wsel      = WS_CURSOR;
				cmd.cursor_op = CO_INC;
				cmd.out_load  = 1'b1;
				state_nxt     = S_IDLE;
			end
			S_CLEAR: begin
				cmd.mem_we  = 1'b1;
				cmd.wsel    = WS_BLANK;
				cmd.rd_ptr  = 1'b1;
				cmd.ptr_inc = 1'b1;
				if (stat.ptr_last) begin
					cmd.cursor_op = CO_ZERO;
					cmd.out_load  = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			S_READ: begin
				cmd.out_load     = 1'b1;
				cmd.out_from_mem = 1'b1;
				state_nxt        = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// checks
	`TCSW_ASSERT_NOW(a_out_load_free, cmd.out_load, stat.out_free, "result loaded over a held word")
	`TCSW_ASSERT_NOW(a_copy_port, stat.copy_pending, !cmd.mem_we, "write port conflict with copy")
	`TCSW_ASSERT_NOW(a_put_col0, state_q == S_PUT, !stat.line_full && !stat.copy_pending, "put with cursor not at line start")
	`TCSW_ASSERT_NOW(a_read_entry, state_q == S_READ, $past(state_q) == S_IDLE, "read state not entered from idle")

endmodule
